// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the metronome click generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and reset
`define MCG_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// block clock and reset by their usual names
`define MCG_ASSERT(lbl, prop, msg) \
   `MCG_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ----- src/mcg_pkg.sv -----
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared constants, command type and quarter-wave sine table.
// ----------------------------------------------------------------------------
package mcg_pkg;

   // sine table
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
   localparam int QTR_W            = IDX_W - 2;
   localparam int QTR_N            = 1 << QTR_W;
   localparam int SINE_W           = 24;
   localparam int MAG_W            = SINE_W - 1;

   // fixed-point constants
   localparam logic [24:0] ENV_ONE  = 25'h100_0000;   // 1.0 in Q1.24
   localparam logic [16:0] GAIN_MAX = 17'h1_0000;     // 1.0 in Q1.16

   // register reset values
   localparam logic [30:0] PHASE_STEP_RST = 31'd93639000;
   localparam logic [23:0] DECAY_RST      = 24'd16757099;
   localparam logic [16:0] OUT_GAIN_RST   = 17'd32768;
   localparam logic [15:0] K_STEP_RST     = 16'd852;
   localparam logic [15:0] K_GAIN_RST     = 16'd4150;
   localparam logic [15:0] K_ENV_RST      = 16'd2110;

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_K_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_K_GAIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_K_ENV      = 3'd5;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;  // take request, beat logic
   localparam logic [OP_W-1:0] OP_DECAY  = 4'd2;  // env * decay
   localparam logic [OP_W-1:0] OP_STEP   = 4'd3;  // store env, step smoother mul
   localparam logic [OP_W-1:0] OP_GAIN   = 4'd4;  // update step, gain smoother mul
   localparam logic [OP_W-1:0] OP_PHASE  = 4'd5;  // update gain + phase, env mul
   localparam logic [OP_W-1:0] OP_ENVS   = 4'd6;  // update env smoother, sine read
   localparam logic [OP_W-1:0] OP_GE     = 4'd7;  // gain * env
   localparam logic [OP_W-1:0] OP_GS     = 4'd8;  // (gain*env) * sine

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            load_out;
   } mcg_cmd_type;

   typedef logic [QTR_N-1:0][MAG_W-1:0] sine_qtr_type;

   localparam longint POLY_ONE   = 64'sd1073741824;
   localparam longint SINE_MAX_V = 64'sd8388607;

   // quarter-wave odd polynomial, argument k/QTR_N of a quarter turn
   function automatic logic [MAG_W-1:0] sine_mag(input int k);
      longint t;
      longint t2;
      longint acc;
      longint v;
      t   = longint'(k) <<< (30 - QTR_W);
      t2  = (t * t) / POLY_ONE;
      acc = -64'sd3864;
      acc = 64'sd172272 + acc * t2 / POLY_ONE;
      acc = -64'sd5026995 + acc * t2 / POLY_ONE;
      acc = 64'sd85569306 + acc * t2 / POLY_ONE;
      acc = -64'sd693598668 + acc * t2 / POLY_ONE;
      acc = 64'sd1686629713 + acc * t2 / POLY_ONE;
      v   = acc * t / POLY_ONE;
      v   = (v + 64) / 128;
      if (v < 0) begin
         v = 0;
      end
      if (v > SINE_MAX_V) begin
         v = SINE_MAX_V;
      end
      return v[MAG_W-1:0];
   endfunction

   function automatic sine_qtr_type build_sine_qtr();
      sine_qtr_type tbl;
      int i;
      for (i = 0; i < QTR_N; i++) begin
         tbl[i] = sine_mag(i);
      end
      return tbl;
   endfunction

   localparam sine_qtr_type      SINE_QTR  = build_sine_qtr();
   localparam logic [MAG_W-1:0]  SINE_PEAK = sine_mag(QTR_N);

endpackage

// ----- src/mcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcg_ctrl
// Sequencer: steps one request through the shared multiplier schedule.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcg_ctrl import mcg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_playing,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mcg_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DECAY = 4'd1;
   localparam logic [3:0] ST_STEP  = 4'd2;
   localparam logic [3:0] ST_GAIN  = 4'd3;
   localparam logic [3:0] ST_PHASE = 4'd4;
   localparam logic [3:0] ST_ENVS  = 4'd5;
   localparam logic [3:0] ST_GE    = 4'd6;
   localparam logic [3:0] ST_GS    = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NOP;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = req_playing ? ST_DECAY : ST_OUT;
            end
         end
         ST_DECAY: begin
            cmd.op   = OP_DECAY;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.op   = OP_STEP;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.op   = OP_GAIN;
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            cmd.op   = OP_PHASE;
            state_in = ST_ENVS;
         end
         ST_ENVS: begin
            cmd.op   = OP_ENVS;
            state_in = ST_GE;
         end
         ST_GE: begin
            cmd.op   = OP_GE;
            state_in = ST_GS;
         end
         ST_GS: begin
            cmd.op   = OP_GS;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MCG_ASSERT(a_stop_to_out, (req_valid && req_ready && !req_playing) |=> (state_ff == ST_OUT), "stopped request must go straight to output")
   `MCG_ASSERT(a_rsp_from_out, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT), "response raised outside output state")
   `MCG_ASSERT(a_out_stall, (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT && rsp_valid_ff), "pending response overrun")

endmodule

// ----- src/mcg_datapath.sv -----
// ----------------------------------------------------------------------------
// mcg_datapath
// Config registers, beat/envelope state, smoothers, phase, sine and output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcg_datapath import mcg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mcg_cmd_type          cmd,
   input  logic                 req_playing,
   input  logic                 req_block_start,
   input  logic [23:0]          req_frames_to_beat,
   input  logic [23:0]          req_frames_per_beat,
   input  logic [4:0]           req_beat_number,
   input  logic [4:0]           req_beats_per_bar,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]          csr_wdata,
   output logic signed [23:0]   rsp_sample
);

   // configuration
   logic [30:0] phase_step_ff, phase_step_in;
   logic [23:0] decay_ff, decay_in;
   logic [16:0] out_gain_ff, out_gain_in;
   logic [15:0] k_step_ff, k_step_in;
   logic [15:0] k_gain_ff, k_gain_in;
   logic [15:0] k_env_ff, k_env_in;

   // frame state
   logic [23:0] countdown_ff, countdown_in;
   logic        was_playing_ff, was_playing_in;
   logic        fresh_ff, fresh_in;
   logic        octave_ff, octave_in;
   logic        mute_ff, mute_in;
   logic [31:0] tone_ff, tone_in;
   logic [24:0] envl_ff, envl_in;
   logic [31:0] step_sm_ff, step_sm_in;
   logic [24:0] env_sm_ff, env_sm_in;
   logic [16:0] gain_sm_ff, gain_sm_in;

   // payload pipeline
   logic signed [58:0] prod_ff, prod_in;
   logic signed [23:0] sine_ff, sine_in;
   logic signed [23:0] sample_ff, sample_in;

   // beat logic temporaries
   logic [23:0] cd_v;
   logic        oct_v;
   logic        fr_v;

   // shared multiplier
   logic signed [33:0] mul_a;
   logic signed [24:0] mul_b;
   logic               mul_en;
   logic signed [58:0] mul_p;

   logic signed [33:0] step_diff, gain_diff, env_diff;
   logic signed [42:0] q;         // floor(prod / 2^16)

   // sine lookup
   logic [IDX_W-1:0]   sin_idx;
   logic [1:0]         sin_quad;
   logic [QTR_W-1:0]   sin_j, sin_jm;
   logic [MAG_W-1:0]   sin_mag;
   logic signed [23:0] sin_val;

   // output rounding
   logic signed [58:0] trunc_adj;
   logic signed [34:0] scaled;
   logic signed [23:0] sat_val;

   assign step_diff = $signed({3'd0, phase_step_ff}) - $signed({2'd0, step_sm_ff});
   assign gain_diff = $signed({17'd0, out_gain_ff}) - $signed({17'd0, gain_sm_ff});
   assign env_diff  = $signed({9'd0, envl_ff}) - $signed({9'd0, env_sm_ff});
   assign q         = prod_ff[58:16];
   assign mul_p     = mul_a * mul_b;

   // quarter-wave lookup, mirrored in odd quadrants, negated in the lower half
   assign sin_idx  = tone_ff[31 -: IDX_W];
   assign sin_quad = sin_idx[IDX_W-1 -: 2];
   assign sin_j    = sin_idx[QTR_W-1:0];
   assign sin_jm   = QTR_W'(~sin_j) + QTR_W'(1);

   always_comb begin
      if (sin_quad[0]) begin
         sin_mag = (sin_j == '0) ? SINE_PEAK : SINE_QTR[sin_jm];
      end else begin
         sin_mag = SINE_QTR[sin_j];
      end
      sin_val = sin_quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
   end

   // truncate toward zero, then saturate to Q1.23
   assign trunc_adj = prod_ff[58] ? (prod_ff + 59'sd16777215) : prod_ff;
   assign scaled    = trunc_adj[58:24];

   always_comb begin
      if (scaled > 35'sd8388607) begin
         sat_val = 24'sh7F_FFFF;
      end else if (scaled < -35'sd8388608) begin
         sat_val = 24'sh80_0000;
      end else begin
         sat_val = scaled[23:0];
      end
   end

   // configuration writes
   always_comb begin
      phase_step_in = phase_step_ff;
      decay_in      = decay_ff;
      out_gain_in   = out_gain_ff;
      k_step_in     = k_step_ff;
      k_gain_in     = k_gain_ff;
      k_env_in      = k_env_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_in = csr_wdata;
            CSR_DECAY:      decay_in      = csr_wdata[23:0];
            CSR_OUT_GAIN: begin
               out_gain_in = (csr_wdata[16:0] > GAIN_MAX) ? GAIN_MAX : csr_wdata[16:0];
            end
            CSR_K_STEP:     k_step_in     = csr_wdata[15:0];
            CSR_K_GAIN:     k_gain_in     = csr_wdata[15:0];
            CSR_K_ENV:      k_env_in      = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // sequenced work
   always_comb begin
      countdown_in   = countdown_ff;
      was_playing_in = was_playing_ff;
      fresh_in       = fresh_ff;
      octave_in      = octave_ff;
      mute_in        = mute_ff;
      tone_in        = tone_ff;
      envl_in        = envl_ff;
      step_sm_in     = step_sm_ff;
      env_sm_in      = env_sm_ff;
      gain_sm_in     = gain_sm_ff;
      sine_in        = sine_ff;
      sample_in      = sample_ff;
      cd_v           = countdown_ff;
      oct_v          = octave_ff;
      fr_v           = fresh_ff;
      mul_a          = '0;
      mul_b          = '0;
      mul_en         = 1'b0;
      case (cmd.op)
         OP_ACCEPT: begin
            if (!req_playing) begin
               was_playing_in = 1'b0;
               mute_in        = 1'b1;
            end else begin
               mute_in = 1'b0;
               if (req_block_start) begin
                  cd_v  = req_frames_to_beat;
                  oct_v = (req_beat_number == 5'd1);
                  fr_v  = !was_playing_ff;
                  if (!was_playing_ff) begin
                     tone_in    = '0;
                     step_sm_in = {1'b0, phase_step_ff};
                     env_sm_in  = '0;
                     gain_sm_in = '0;
                  end
               end
               if (cd_v == '0) begin
                  envl_in = ENV_ONE;
                  cd_v    = req_frames_per_beat;
                  oct_v   = fr_v || (req_beat_number == req_beats_per_bar);
               end
               countdown_in   = cd_v - 24'd1;
               octave_in      = oct_v;
               fresh_in       = fr_v;
               was_playing_in = 1'b1;
            end
         end
         OP_DECAY: begin
            mul_a  = $signed({9'd0, envl_ff});
            mul_b  = $signed({1'b0, decay_ff});
            mul_en = 1'b1;
         end
         OP_STEP: begin
            envl_in = prod_ff[48:24];
            mul_a   = step_diff;
            mul_b   = $signed({9'd0, k_step_ff});
            mul_en  = 1'b1;
         end
         OP_GAIN: begin
            step_sm_in = step_sm_ff + q[31:0];
            mul_a      = gain_diff;
            mul_b      = $signed({9'd0, k_gain_ff});
            mul_en     = 1'b1;
         end
         OP_PHASE: begin
            gain_sm_in = gain_sm_ff + q[16:0];
            tone_in    = tone_ff + (octave_ff ? {step_sm_ff[30:0], 1'b0} : step_sm_ff);
            mul_a      = env_diff;
            mul_b      = $signed({9'd0, k_env_ff});
            mul_en     = 1'b1;
         end
         OP_ENVS: begin
            env_sm_in = env_sm_ff + q[24:0];
            sine_in   = sin_val;
         end
         OP_GE: begin
            mul_a  = $signed({9'd0, env_sm_ff});
            mul_b  = $signed({8'd0, gain_sm_ff});
            mul_en = 1'b1;
         end
         OP_GS: begin
            mul_a  = $signed({9'd0, prod_ff[40:16]});   // gain*env in Q1.24
            mul_b  = $signed({sine_ff[23], sine_ff});
            mul_en = 1'b1;
         end
         default: ;
      endcase
      if (cmd.load_out) begin
         sample_in = mute_ff ? 24'sd0 : sat_val;
      end
      prod_in = mul_en ? mul_p : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RST;
         decay_ff       <= DECAY_RST;
         out_gain_ff    <= OUT_GAIN_RST;
         k_step_ff      <= K_STEP_RST;
         k_gain_ff      <= K_GAIN_RST;
         k_env_ff       <= K_ENV_RST;
         countdown_ff   <= '0;
         was_playing_ff <= 1'b0;
         fresh_ff       <= 1'b0;
         octave_ff      <= 1'b0;
         mute_ff        <= 1'b0;
         tone_ff        <= '0;
         envl_ff        <= ENV_ONE;
         step_sm_ff     <= '0;
         env_sm_ff      <= '0;
         gain_sm_ff     <= OUT_GAIN_RST;
      end else begin
         phase_step_ff  <= phase_step_in;
         decay_ff       <= decay_in;
         out_gain_ff    <= out_gain_in;
         k_step_ff      <= k_step_in;
         k_gain_ff      <= k_gain_in;
         k_env_ff       <= k_env_in;
         countdown_ff   <= countdown_in;
         was_playing_ff <= was_playing_in;
         fresh_ff       <= fresh_in;
         octave_ff      <= octave_in;
         mute_ff        <= mute_in;
         tone_ff        <= tone_in;
         envl_ff        <= envl_in;
         step_sm_ff     <= step_sm_in;
         env_sm_ff      <= env_sm_in;
         gain_sm_ff     <= gain_sm_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      sine_ff   <= sine_in;
      sample_ff <= sample_in;
   end

   assign rsp_sample = sample_ff;

   `MCG_ASSERT(a_env_bound, envl_ff <= ENV_ONE, "envelope above 1.0")
   `MCG_ASSERT(a_env_sm_bound, env_sm_ff <= ENV_ONE, "envelope smoother overshoot")
   `MCG_ASSERT(a_gain_sm_bound, (gain_sm_ff <= GAIN_MAX) && (out_gain_ff <= GAIN_MAX), "gain above unity")

endmodule

// ----- src/metronome_click_generator_unit.sv -----
// ----------------------------------------------------------------------------
// metronome_click_generator_unit
// Schedule: after acceptance a playing request walks an eight-step schedule
//   around one shared 34x25 multiplier (six products); a stopped request goes
//   straight to the output step. The sample and its valid flag are registered.
//   A new request is taken only after the previous one has loaded its sample;
//   the output step waits while the previous response is still pending.
// Reset (sync, active high): registers to their defaults, envelope at 1.0.
// ----------------------------------------------------------------------------
module metronome_click_generator_unit import mcg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel: one audio frame of transport facts
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_playing,
   input  logic                 req_block_start,
   input  logic [23:0]          req_frames_to_beat,
   input  logic [23:0]          req_frames_per_beat,
   input  logic [4:0]           req_beat_number,
   input  logic [4:0]           req_beats_per_bar,
   // response channel: one Q1.23 sample per request
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [23:0]   rsp_sample,
   // configuration writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]          csr_wdata
);

   // Controller walks the schedule; the datapath holds the config and data registers.
   // Sequence for a playing request, one state per cycle:
   //   accept  beat countdown, retrigger, octave select
   //   decay   envelope * decay
   //   step    store envelope, step smoother product
   //   gain    update step, gain smoother product
   //   phase   update gain and phase, envelope smoother product
   //   envs    update envelope smoother, sine lookup
   //   ge      gain * envelope
   //   gs      times sine
   //   out     round, saturate, load output register (waits if full)
   // The output register frees the request side once loaded, so the next
   // request is taken while the previous sample is still pending.

   mcg_cmd_type cmd;

   mcg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_playing (req_playing),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   mcg_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_playing         (req_playing),
      .req_block_start     (req_block_start),
      .req_frames_to_beat  (req_frames_to_beat),
      .req_frames_per_beat (req_frames_per_beat),
      .req_beat_number     (req_beat_number),
      .req_beats_per_bar   (req_beats_per_bar),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_sample          (rsp_sample)
   );

endmodule
